@@ rtl/core/mtsa_pkg.sv @@
// shared constants, types and control structs for the sorted-list merge block
// no dependencies; imported by mtsa_list and merge_two_sorted_arrays

package mtsa_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int DATA_WIDTH = 32;
    // count must hold the depth itself
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MERGE  = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    typedef struct packed {
        logic  wr_en;
        t_data wr_data;
        logic  adv;
        logic  clr;
    } t_list_ctl;

    typedef struct packed {
        t_cnt count;
        t_cnt ptr;
        logic full;
        logic remain;
    } t_list_sts;

endpackage

@@ rtl/core/mtsa_list.sv @@
// one list: entry memory with registered read, fill count and read pointer
// depends on mtsa_pkg

module mtsa_list
    import mtsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_list_ctl i_ctl,
    output t_list_sts o_sts,
    output t_data     o_head
);

    t_data r_mem [0:LIST_DEPTH-1];
    t_data r_rd_data;
    t_cnt  r_count;
    t_cnt  r_ptr;
    t_cnt  n_count;
    t_cnt  n_ptr;
    logic  full;

    assign full = (r_count == t_cnt'(LIST_DEPTH));

    always_comb begin
        n_count = r_count;
        n_ptr   = r_ptr;
        if (i_ctl.clr) begin
            n_count = '0;
            n_ptr   = '0;
        end else begin
            if (i_ctl.wr_en && !full) begin
                n_count = r_count + t_cnt'(1);
            end
            if (i_ctl.adv) begin
                n_ptr = r_ptr + t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    // read the entry the pointer will hold next cycle, so head tracks r_ptr
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= i_ctl.wr_data;
        end
        r_rd_data <= r_mem[n_ptr[IDX_W-1:0]];
    end

    assign o_head        = r_rd_data;
    assign o_sts.count   = r_count;
    assign o_sts.ptr     = r_ptr;
    assign o_sts.full    = full;
    assign o_sts.remain  = (r_ptr < r_count);

endmodule

@@ rtl/core/merge_two_sorted_arrays.sv @@
// top level of the sorted-list merge block: command decode, merge sequencer, output register
// depends on mtsa_pkg and mtsa_list
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries i_command and i_value.
//   CMD_LOAD_A / CMD_LOAD_B append i_value to list A or B, one transfer per
//   cycle, and give no result; a load into a full list is dropped and marks
//   the next run as overflowed. command 3 is ignored.
//   CMD_MERGE starts a run: the block emits every loaded value on the output
//   channel (o_out_valid / i_out_ready), in ascending signed order for sorted lists, list B
//   winning ties, with o_last on the final result. a run on two empty lists
//   gives a single result with o_empty_res set and value 0.
//   after the merge transfer the sequencer enters ST_MERGE and the first result
//   goes into the output register once it is free (both list heads are read
//   out while loading), then one result per cycle while the output slot is free.
//   the rate is set by the registered read of each list memory, re-read at
//   the next pointer every cycle. no input is taken during a run; loads are
//   taken again once the last result is in the output register.
//   a receiver stall holds the output register and pauses the run.
//   reset (synchronous, active low) empties both lists and clears the
//   overflow mark; list memories are not cleared.

module merge_two_sorted_arrays
    import mtsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_command,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_merged_value,
    output logic              o_last,
    output logic              o_empty_res,
    output logic              o_overflowed
);

    t_state    r_state, n_state;
    logic      r_ovf, n_ovf;
    logic      r_out_valid;
    t_data     r_out_value;
    logic      r_out_last;
    logic      r_out_empty;
    logic      r_out_ovf;

    t_list_ctl ctl_a, ctl_b;
    t_list_sts sts_a, sts_b;
    t_data     head_a, head_b;

    logic      in_xfer;
    logic      slot_free;
    logic      emit;
    logic      take_a;
    t_data     n_value;
    logic      n_last;
    logic      n_empty;

    mtsa_list u_list_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_a),
        .o_sts   (sts_a),
        .o_head  (head_a)
    );

    mtsa_list u_list_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_b),
        .o_sts   (sts_b),
        .o_head  (head_b)
    );

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign take_a     = sts_a.remain && (!sts_b.remain || (head_a < head_b));

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        ctl_a   = '{wr_en: 1'b0, wr_data: i_value, adv: 1'b0, clr: 1'b0};
        ctl_b   = '{wr_en: 1'b0, wr_data: i_value, adv: 1'b0, clr: 1'b0};
        emit    = 1'b0;
        n_value = '0;
        n_last  = 1'b0;
        n_empty = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    case (i_command)
                        CMD_LOAD_A: begin
                            ctl_a.wr_en = 1'b1;
                            if (sts_a.full) begin
                                n_ovf = 1'b1;
                            end
                        end
                        CMD_LOAD_B: begin
                            ctl_b.wr_en = 1'b1;
                            if (sts_b.full) begin
                                n_ovf = 1'b1;
                            end
                        end
                        CMD_MERGE: begin
                            n_state = ST_MERGE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (!sts_a.remain && !sts_b.remain) begin
                        // both lists empty at the start of the run
                        n_last  = 1'b1;
                        n_empty = 1'b1;
                    end else if (take_a) begin
                        n_value   = head_a;
                        ctl_a.adv = 1'b1;
                        n_last    = (sts_a.ptr + t_cnt'(1) == sts_a.count) && !sts_b.remain;
                    end else begin
                        n_value   = head_b;
                        ctl_b.adv = 1'b1;
                        n_last    = (sts_b.ptr + t_cnt'(1) == sts_b.count) && !sts_a.remain;
                    end
                    if (n_last) begin
                        ctl_a.clr = 1'b1;
                        ctl_b.clr = 1'b1;
                        n_ovf     = 1'b0;
                        n_state   = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value <= n_value;
            r_out_last  <= n_last;
            r_out_empty <= n_empty;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_last         = r_out_last;
    assign o_empty_res    = r_out_empty;
    assign o_overflowed   = r_out_ovf;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_last) |=> (r_state == ST_LOAD && sts_a.count == '0 &&
                              sts_b.count == '0 && !r_ovf))
        else $error("run did not end cleanly after last result");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sts_a.ptr <= sts_a.count) && (sts_b.ptr <= sts_b.count))
        else $error("read pointer passed list count");

    a_emit_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !n_empty) |-> (sts_a.remain || sts_b.remain))
        else $error("result emitted with both lists drained");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (!ctl_a.wr_en && !ctl_b.wr_en))
        else $error("list written during a merge run");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_empty) |=> (sts_a.count == '0 && sts_b.count == '0 &&
                               $past(sts_a.count) == '0 && $past(sts_b.count) == '0))
        else $error("empty result with loaded entries");

endmodule

@@ test/tb_merge_two_sorted_arrays.sv @@
// testbench for merge_two_sorted_arrays: loads lists A and B, runs merges, checks every result
// depends on mtsa_pkg and the merge_two_sorted_arrays rtl; predicts merged streams itself
`timescale 1ns / 100ps

module tb_merge_two_sorted_arrays;
    import mtsa_pkg::*;

    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam longint DATA_MAX = 64'sd2147483647;
    localparam longint DATA_MIN = -64'sd2147483648;
    localparam int RANDOM_ITEMS = 270;
    localparam int CALM_FROM = 230;

    typedef struct packed {
        t_data value;
        logic  last;
        logic  empty_res;
        logic  overflowed;
    } t_merge_word;

    class merge_checker;
        t_data list_a[$];
        t_data list_b[$];
        logic drop_mark;
        t_merge_word words_due[$];
        int mismatches;
        int runs;
        int empty_runs;
        int drops;
        int words_checked;

        function new();
            drop_mark = 1'b0;
            mismatches = 0;
            runs = 0;
            empty_runs = 0;
            drops = 0;
            words_checked = 0;
        endfunction

        // update list state for one input transfer; a merge queues its whole stream
        function void note_transfer(logic [1:0] cmd, t_data v);
            int ia;
            int ib;
            int total;
            logic take_a;
            t_merge_word w;
            case (cmd)
                CMD_LOAD_A: begin
                    if (list_a.size() < LIST_DEPTH) begin
                        list_a.push_back(v);
                    end else begin
                        drop_mark = 1'b1;
                        drops++;
                    end
                end
                CMD_LOAD_B: begin
                    if (list_b.size() < LIST_DEPTH) begin
                        list_b.push_back(v);
                    end else begin
                        drop_mark = 1'b1;
                        drops++;
                    end
                end
                CMD_MERGE: begin
                    ia = 0;
                    ib = 0;
                    total = list_a.size() + list_b.size();
                    runs++;
                    if (total == 0) begin
                        w.value = '0;
                        w.last = 1'b1;
                        w.empty_res = 1'b1;
                        w.overflowed = drop_mark;
                        words_due.push_back(w);
                        empty_runs++;
                    end
                    while (ia + ib < total) begin
                        // list b wins a tie
                        take_a = (ia < list_a.size()) &&
                                 (ib >= list_b.size() || list_a[ia] < list_b[ib]);
                        if (take_a) begin
                            w.value = list_a[ia];
                            ia++;
                        end else begin
                            w.value = list_b[ib];
                            ib++;
                        end
                        w.last = (ia + ib == total);
                        w.empty_res = 1'b0;
                        w.overflowed = drop_mark;
                        words_due.push_back(w);
                    end
                    list_a.delete();
                    list_b.delete();
                    drop_mark = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_merge_word got);
            t_merge_word want;
            words_checked++;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result value %0d last %0b empty %0b ovf %0b",
                             $realtime, got.value, got.last, got.empty_res, got.overflowed);
                return;
            end
            want = words_due.pop_front();
            if (got.value !== want.value || got.last !== want.last ||
                got.empty_res !== want.empty_res || got.overflowed !== want.overflowed) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected value %0d last %0b empty %0b ovf %0b, %s %0d %0b %0b %0b",
                             $realtime, want.value, want.last, want.empty_res, want.overflowed,
                             "got", got.value, got.last, got.empty_res, got.overflowed);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = CMD_LOAD_A;
    t_data       i_value = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_data       o_merged_value;
    logic        o_last;
    logic        o_empty_res;
    logic        o_overflowed;

    merge_checker sb = new();
    t_merge_word seen_word;
    int random_items = 0;
    bit calm = 1'b0;
    int stall_left = 0;
    int n_noise;
    logic [1:0] noise_cmd;
    int guard;
    int leftover;

    merge_two_sorted_arrays DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_merged_value (o_merged_value),
        .o_last         (o_last),
        .o_empty_res    (o_empty_res),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("merge_two_sorted_arrays: mismatch");
        $finish;
    end

    // receiver stalls in random bursts until calm is set
    always @(posedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_transfer(i_command, i_value);
            if (o_out_valid && i_out_ready) begin
                seen_word = '{o_merged_value, o_last, o_empty_res, o_overflowed};
                sb.check_word(seen_word);
            end
        end
    end

    // returns at the edge where the transfer happens, valid still high
    task automatic send_item(logic [1:0] cmd, t_data v);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_value <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.words_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic longint next_up(longint v, int unsigned step_max);
        longint n;
        n = v + longint'($urandom_range(0, step_max));
        return (n > DATA_MAX) ? DATA_MAX : n;
    endfunction

    // both lists ascending from a shared start so the merge interleaves them
    task automatic send_run(int na, int nb);
        t_data seq_a[$];
        t_data seq_b[$];
        longint base;
        longint cur;
        int unsigned step_max;
        int ia;
        int ib;
        case ($urandom_range(0, 3))
            0: base = DATA_MIN + $urandom_range(0, 40);
            1: base = DATA_MAX - $urandom_range(0, 2000);
            2: base = longint'($urandom_range(0, 400)) - 200;
            default: base = longint'(int'($urandom));
        endcase
        case ($urandom_range(0, 3))
            0: step_max = 2;
            1: step_max = 1000;
            2: step_max = 1 << 24;
            default: step_max = 1 << 30;
        endcase
        cur = base;
        repeat (na) begin
            seq_a.push_back(t_data'(cur));
            cur = next_up(cur, step_max);
        end
        cur = base;
        repeat (nb) begin
            seq_b.push_back(t_data'(cur));
            cur = next_up(cur, step_max);
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_item(CMD_LOAD_A, seq_a[ia]);
                ia++;
            end else begin
                send_item(CMD_LOAD_B, seq_b[ib]);
                ib++;
            end
            random_items++;
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_IGNORED, t_data'($urandom));
        end
        send_item(CMD_MERGE, t_data'($urandom));
        random_items++;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty run, then extremes and ties on both sides
        send_item(CMD_MERGE, 32'sd0);
        send_item(CMD_LOAD_A, t_data'(DATA_MIN));
        send_item(CMD_LOAD_B, t_data'(DATA_MIN));
        send_item(CMD_LOAD_A, -32'sd5);
        send_item(CMD_LOAD_A, 32'sd0);
        send_item(CMD_LOAD_B, 32'sd7);
        send_item(CMD_LOAD_A, 32'sd7);
        send_item(CMD_IGNORED, t_data'(DATA_MAX));
        send_item(CMD_LOAD_A, t_data'(DATA_MAX));
        send_item(CMD_LOAD_B, t_data'(DATA_MAX));
        send_item(CMD_MERGE, -32'sd1);
        send_item(CMD_LOAD_B, 32'sd3);
        send_item(CMD_MERGE, 32'sd0);
        send_item(CMD_LOAD_A, -32'sd1);
        send_item(CMD_MERGE, 32'sd0);
        send_item(CMD_LOAD_A, 32'sd0);
        send_item(CMD_LOAD_B, 32'sd0);
        send_item(CMD_MERGE, 32'sd0);
        // hold off until the directed runs are all out
        drain_results();

        // full list with dropped loads, then both lists full
        send_run(LIST_DEPTH + 2, 3);
        send_run(LIST_DEPTH, LIST_DEPTH + 1);

        while (random_items < RANDOM_ITEMS) begin
            calm = (random_items >= CALM_FROM);
            case ($urandom_range(0, 15))
                0: send_run(LIST_DEPTH + $urandom_range(0, 2), $urandom_range(0, 4));
                1: send_run($urandom_range(0, 4), LIST_DEPTH + $urandom_range(0, 2));
                2, 3: begin
                    // unordered values and stray commands
                    n_noise = $urandom_range(1, 8);
                    repeat (n_noise) begin
                        case ($urandom_range(0, 2))
                            0: noise_cmd = CMD_LOAD_A;
                            1: noise_cmd = CMD_LOAD_B;
                            default: noise_cmd = CMD_IGNORED;
                        endcase
                        send_item(noise_cmd, t_data'($urandom));
                        if (noise_cmd != CMD_IGNORED)
                            random_items++;
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        send_item(CMD_MERGE, t_data'($urandom));
                        random_items++;
                    end
                end
                4: begin
                    send_run($urandom_range(0, 6), $urandom_range(0, 6));
                    drain_results();
                end
                default: send_run($urandom_range(0, 6), $urandom_range(0, 6));
            endcase
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (sb.words_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        leftover = sb.words_due.size();

        $display("ran %0d loads and merges in the random part, %0d merge runs (%0d empty)",
                 random_items, sb.runs, sb.empty_runs);
        $display("checked %0d results, %0d loads dropped on full lists, %0d results missing",
                 sb.words_checked, sb.drops, leftover);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("merge_two_sorted_arrays: match");
        end else begin
            $display("merge_two_sorted_arrays: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/mtsa_pkg.sv
rtl/core/mtsa_list.sv
rtl/core/merge_two_sorted_arrays.sv
test/tb_merge_two_sorted_arrays.sv
